### hw/rtl/base64_stream_decoder_assert.svh
// Assertion macros for the base64 stream decoder.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define B64D_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");
// Next-cycle implication, disabled during reset.
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT_IMPL(label, ante, cons)
`define B64D_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/b64d_pkg.sv
// Types and constants shared by the base64 stream decoder modules.
// No dependencies.
package b64d_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LENGTH = 2'd1,
        ST_PAD    = 2'd2,
        ST_CHAR   = 2'd3
    } status_t;

    // Character codes
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    // Sextet offsets
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Quartet positions
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // Byte counts of a decoded quartet
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_final;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        status_t    status;
        logic       run_last;
    } out_item_t;

    // Work handed from front to back: bytes of one quartet or one error
    typedef struct packed {
        logic        is_err;
        status_t     status;
        logic [1:0]  count;
        logic [23:0] bytes;
    } job_t;

    // Queue write port
    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    // Front status
    typedef struct packed {
        logic halted;
    } front_status_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

endpackage

### hw/rtl/base64_stream_decoder.sv
// Base64 stream decoder: top level joining front, job queue and back.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the assert header.
//
// Usage:
//   Input channel chr_valid/chr_ready/chr_data carries one character per
//   item, with in_final set on the last character of a text.
//   Output channel res_valid/res_ready/res_data carries result items: one to
//   three decoded bytes per complete quartet, or a single status item on an
//   error, each group ending with run_last set.
//   Throughput: one character per cycle while the queue has room, one result
//   per cycle while res_ready is high. A quartet gives at most three results
//   in four characters, so the back keeps up. A job's results are offered from
//   the back job register, loaded from the queue entry written at the
//   accepting edge. The job queue holds QUEUE_DEPTH jobs; chr_ready drops
//   only when it is full, which happens only while res_ready is held low.
//   After an error the block keeps accepting characters and drops them,
//   giving no results for them until reset.
//   Reset (rst_n low, asynchronous) clears the quartet, the halt flag, the
//   queue and any result in flight.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                chr_valid,
    output logic                chr_ready,
    input  b64d_pkg::in_item_t  chr_data,
    output logic                res_valid,
    input  logic                res_ready,
    output b64d_pkg::out_item_t res_data
);
    import b64d_pkg::*;

    push_t         push;
    job_t          head;
    queue_status_t q_stat;
    front_status_t f_stat;
    logic          pop;

    // Character intake and classification
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr_data  (chr_data),
        .q_stat    (q_stat),
        .push      (push),
        .stat      (f_stat)
    );

    // Job queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    // Result output
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Checks
    `B64D_ASSERT_IMPL(a_no_push_full, push.valid, !q_stat.full)
    `B64D_ASSERT_NEXT(a_err_halts, push.valid && push.job.is_err, f_stat.halted)
    `B64D_ASSERT_IMPL(a_halt_no_push, f_stat.halted, !push.valid)
    `B64D_ASSERT_IMPL(a_err_is_last, res_valid && !res_data.byte_valid, res_data.run_last)

endmodule

### hw/rtl/b64d_front.sv
// Front of the base64 decoder: accepts characters, tracks the quartet and
// pushes byte or error jobs. Depends on b64d_pkg.
module b64d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   chr_valid,
    output logic                   chr_ready,
    input  b64d_pkg::in_item_t     chr_data,
    input  b64d_pkg::queue_status_t q_stat,
    output b64d_pkg::push_t        push,
    output b64d_pkg::front_status_t stat
);
    import b64d_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;
    status_t     perr_reg, perr_next;
    logic        halted_reg, halted_next;

    logic [7:0]  ch;
    logic        is_pad;
    logic        sx_ok;
    logic [5:0]  sx_val;
    logic        accept;
    push_t       push_w;

    // Take an item whenever the queue has room
    assign chr_ready = !q_stat.full;
    assign accept    = chr_valid && chr_ready;

    // Character classification
    always_comb
    begin
        ch     = chr_data.in_char;
        is_pad = (ch == CHAR_PAD);
        sx_ok  = 1'b1;
        sx_val = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            sx_val = 6'(ch - CHAR_UPPER_A);
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            sx_val = 6'(ch - CHAR_LOWER_A + LOWER_BASE);
        end
        else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
        begin
            sx_val = 6'(ch - CHAR_DIGIT_0 + DIGIT_BASE);
        end
        else if (ch == CHAR_PLUS)
        begin
            sx_val = SEXTET_PLUS;
        end
        else if (ch == CHAR_SLASH)
        begin
            sx_val = SEXTET_SLASH;
        end
        else
        begin
            sx_ok = 1'b0;
        end
    end

    // Quartet state update and job generation
    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        perr_next      = perr_reg;
        halted_next    = halted_reg;
        push_w         = '0;
        if (accept && !halted_reg)
        begin
            if (pos_reg != POS_FOURTH)
            begin
                // first three characters: record errors, shift sextet in, push a length error on in_final
                if (is_pad && pos_reg != POS_THIRD)
                begin
                    perr_next = ST_PAD;
                end
                else if (!is_pad && !sx_ok && perr_reg == ST_OK)
                begin
                    perr_next = ST_CHAR;
                end
                if (is_pad && pos_reg == POS_THIRD)
                begin
                    third_pad_next = 1'b1;
                end
                acc_next = {acc_reg[11:0], sx_val};
                pos_next = pos_reg + 2'd1;
                if (chr_data.in_final)
                begin
                    push_w.valid      = 1'b1;
                    push_w.job.is_err = 1'b1;
                    push_w.job.status = ST_LENGTH;
                end
            end
            else
            begin
                // fourth character: settle errors or emit bytes
                push_w.valid     = 1'b1;
                push_w.job.bytes = {acc_reg, sx_val};
                if (perr_reg != ST_OK)
                begin
                    push_w.job.is_err = 1'b1;
                    push_w.job.status = perr_reg;
                end
                else if (!is_pad && !sx_ok)
                begin
                    push_w.job.is_err = 1'b1;
                    push_w.job.status = ST_CHAR;
                end
                else if (third_pad_reg && !is_pad)
                begin
                    push_w.job.is_err = 1'b1;
                    push_w.job.status = ST_PAD;
                end
                else if (third_pad_reg)
                begin
                    push_w.job.count = CNT_ONE;
                end
                else if (is_pad)
                begin
                    push_w.job.count = CNT_TWO;
                end
                else
                begin
                    push_w.job.count = CNT_THREE;
                end
            end
            // any job clears the quartet; an error also halts
            if (push_w.valid)
            begin
                pos_next       = '0;
                acc_next       = '0;
                third_pad_next = 1'b0;
                perr_next      = ST_OK;
                if (push_w.job.is_err)
                begin
                    halted_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            acc_reg       <= '0;
            third_pad_reg <= 1'b0;
            perr_reg      <= ST_OK;
            halted_reg    <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
            perr_reg      <= perr_next;
            halted_reg    <= halted_next;
        end
    end

    assign push        = push_w;
    assign stat.halted = halted_reg;

endmodule

### hw/rtl/b64d_queue.sv
// Short job queue between decoder front and back, in flip-flops.
// Depends on b64d_pkg.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64d_pkg::push_t         push,
    input  logic                    pop,
    output b64d_pkg::job_t          head,
    output b64d_pkg::queue_status_t stat
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign do_push = push.valid;
    assign do_pop  = pop && (cnt_reg != '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

    assign head          = mem[rd_ptr_reg];
    assign stat.full     = (cnt_reg == CNT_FULL);
    assign stat.nonempty = (cnt_reg != '0);

endmodule

### hw/rtl/b64d_back.sv
// Back of the base64 decoder: plays each job out as one to three result
// items. Depends on b64d_pkg.
module b64d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64d_pkg::job_t          head,
    input  b64d_pkg::queue_status_t q_stat,
    output logic                    pop,
    output logic                    res_valid,
    input  logic                    res_ready,
    output b64d_pkg::out_item_t     res_data
);
    import b64d_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       take;
    logic       done;

    // Current result from the held job
    always_comb
    begin
        res_data = '0;
        last     = 1'b1;
        if (job_reg.is_err)
        begin
            res_data.status = job_reg.status;
        end
        else
        begin
            last                = (idx_reg == job_reg.count - 2'd1);
            res_data.byte_valid = 1'b1;
            res_data.status     = ST_OK;
            case (idx_reg)
                2'd0:    res_data.out_byte = job_reg.bytes[23:16];
                2'd1:    res_data.out_byte = job_reg.bytes[15:8];
                default: res_data.out_byte = job_reg.bytes[7:0];
            endcase
        end
        res_data.run_last = last;
    end

    assign res_valid = busy_reg;
    assign take      = res_valid && res_ready;
    assign done      = take && last;
    assign pop       = q_stat.nonempty && (!busy_reg || done);

    // Sequencing over the results of a job
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Job payload register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
    end

endmodule
